### hw/rtl/pfsc_pkg.sv
// Shared constants, types and codes for the packet field stepper.
`default_nettype none
package pfsc_pkg;

	localparam int FRAME_BYTES = 2048;
	localparam int RULE_COUNT  = 8;

	localparam int ADDR_W  = 11;
	localparam int FLEN_W  = 12;
	localparam int MASK_W  = 5;
	localparam int CNT_W   = 16;
	localparam int FA_W    = $clog2(FRAME_BYTES);
	localparam int LEN_W   = $clog2(FRAME_BYTES + 1);
	localparam int RULE_W  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
	localparam int PA_W    = ((FA_W > ADDR_W) ? FA_W : ADDR_W) + 2;

	// reciprocal for address mod RULE_COUNT
	localparam int RQ_SH   = ADDR_W + 6;
	localparam int RQ_MUL  = (1 << RQ_SH) / RULE_COUNT;
	localparam int RQ_W    = $clog2(RQ_MUL + 1);

	localparam logic [1:0] MODE_WRITE_BYTE = 2'd0;
	localparam logic [1:0] MODE_WRITE_RULE = 2'd1;
	localparam logic [1:0] MODE_ADVANCE    = 2'd2;
	localparam logic [1:0] MODE_READ_BYTE  = 2'd3;

	localparam logic [1:0] ST_FULL    = 2'd0;
	localparam logic [1:0] ST_NOT_IP  = 2'd1;
	localparam logic [1:0] ST_FRAG    = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	localparam logic [0:0] CFG_FRAME_LENGTH  = 1'b0;
	localparam logic [0:0] CFG_CHECKSUM_MASK = 1'b1;

	localparam int CK_IP   = 0;
	localparam int CK_ICMP = 1;
	localparam int CK_IGMP = 2;
	localparam int CK_TCP  = 3;
	localparam int CK_UDP  = 4;

	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_IGMP = 8'd2;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam int ETH_HDR   = 14;
	localparam int IP_MIN    = 20;
	localparam int MIN_FRAME = 34;

	typedef struct packed {
		logic [ADDR_W-1:0] offset;
		logic [2:0]        width;
		logic [31:0]       step;
		logic [31:0]       base;
		logic [31:0]       rmax;
	} rule_t;

	localparam int RULE_BITS = $bits(rule_t);

	typedef struct packed {
		logic            re;
		logic            we;
		logic [FA_W-1:0] addr;
		logic [7:0]      wdata;
	} frm_req_t;

	typedef struct packed {
		logic       done;
		logic [1:0] status;
	} seq_res_t;

endpackage
`default_nettype wire

### hw/rtl/packet_field_step_and_checksum.sv
// Top level: template and rule memories, result stage and configuration.
//
//  channel | signals                                     | direction
//  cfg     | cfg_we, cfg_index, cfg_data                 | in
//  in      | in_valid/in_stall, mode .. rule_max         | in
//  out     | out_valid/out_stall, byte_out, advance_status | out
//
// Byte writes, rule writes and byte reads: one transfer per cycle unless in_stall is high;
// each result passes the s1 stage and then the output register. An advance walks every rule,
// then the VLAN tags and the summed bytes (header, pseudo header and payload), byte-wide
// through the single read port of the template memory.
// Reset clears configuration, rule valid bits and all control; template memory is undefined.
// The output register holds a result while out_stall is high; input stalls during an advance.
`default_nettype none
module packet_field_step_and_checksum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [pfsc_pkg::FLEN_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  mode,
	input  wire logic [pfsc_pkg::ADDR_W-1:0] address,
	input  wire logic [7:0]                  byte_value,
	input  wire logic                        rule_enable,
	input  wire logic [pfsc_pkg::ADDR_W-1:0] rule_offset,
	input  wire logic [2:0]                  rule_width,
	input  wire logic [31:0]                 rule_step,
	input  wire logic [31:0]                 rule_base,
	input  wire logic [31:0]                 rule_max,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       byte_out,
	output logic [1:0]                       advance_status
);
	import pfsc_pkg::*;

	logic [FLEN_W-1:0]     frame_length_q;
	logic [MASK_W-1:0]     cmask_q;
	logic [RULE_COUNT-1:0] rvalid_q;
	logic [LEN_W-1:0]      len;

	logic                  vld_s1;
	logic [1:0]            mode_s1;
	logic [1:0]            sts_s1;
	logic                  oob_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [ADDR_W-1:0]     quot_s1;
	logic                  en_s1;
	rule_t                 ru_s1;

	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic [1:0]            status_q;

	logic                  acc;
	logic                  oob_in;
	logic                  s1_go;
	logic                  out_load;
	logic [ADDR_W+RQ_W-1:0] prod;
	logic [ADDR_W-1:0]     rem0;
	logic [ADDR_W-1:0]     rem;
	logic [RULE_W-1:0]     ridx;
	logic                  rule_we;

	logic                  seq_busy;
	seq_res_t              seq_res;
	frm_req_t              seq_req;
	logic                  seq_rule_re;
	logic [RULE_W-1:0]     seq_rule_raddr;
	rule_t                 rule_rdata;
	logic [RULE_BITS-1:0]  rule_rword;
	logic [7:0]            frame_rdata;
	logic                  frm_we;
	logic                  frm_re;
	logic [FA_W-1:0]       frm_addr;
	logic [7:0]            frm_wdata;

	assign len      = (32'(frame_length_q) > 32'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) :
	                  LEN_W'(frame_length_q);
	assign s1_go    = !out_valid_q || !out_stall;
	assign out_load = vld_s1 && s1_go;
	assign in_stall = seq_busy || (vld_s1 && !s1_go);
	assign acc      = in_valid && !in_stall;
	assign oob_in   = 32'(address) >= 32'(FRAME_BYTES);
	assign prod     = (ADDR_W+RQ_W)'(address) * (ADDR_W+RQ_W)'(RQ_MUL);

	// address mod rule count: reciprocal quotient may come out one short
	assign rem0    = addr_s1 - ADDR_W'(quot_s1 * ADDR_W'(RULE_COUNT));
	assign rem     = (rem0 >= ADDR_W'(RULE_COUNT)) ? (rem0 - ADDR_W'(RULE_COUNT)) : rem0;
	assign ridx    = RULE_W'(rem);
	assign rule_we = vld_s1 && (mode_s1 == MODE_WRITE_RULE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= '0;
			cmask_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_LENGTH:  frame_length_q <= cfg_data;
				CFG_CHECKSUM_MASK: cmask_q        <= cfg_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (rule_we) begin
			rvalid_q[ridx] <= en_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (seq_res.done) begin
				vld_s1 <= 1'b1;
			end else if (acc && (mode != MODE_ADVANCE)) begin
				vld_s1 <= 1'b1;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= vld_s1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res.done) begin
			mode_s1 <= MODE_ADVANCE;
			sts_s1  <= seq_res.status;
			oob_s1  <= 1'b1;
		end else if (acc && (mode != MODE_ADVANCE)) begin
			mode_s1      <= mode;
			sts_s1       <= ST_NONE;
			oob_s1       <= oob_in;
			addr_s1      <= address;
			quot_s1      <= ADDR_W'(prod >> RQ_SH);
			en_s1        <= rule_enable;
			ru_s1.offset <= rule_offset;
			ru_s1.width  <= rule_width;
			ru_s1.step   <= rule_step;
			ru_s1.base   <= rule_base;
			ru_s1.rmax   <= rule_max;
		end
		if (out_load) begin
			byte_q   <= ((mode_s1 == MODE_READ_BYTE) && !oob_s1) ? frame_rdata : 8'h00;
			status_q <= sts_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_out       = byte_q;
	assign advance_status = status_q;

	// sequencer owns the template memory while it runs
	always_comb begin
		if (seq_busy) begin
			frm_we    = seq_req.we;
			frm_re    = seq_req.re;
			frm_addr  = seq_req.addr;
			frm_wdata = seq_req.wdata;
		end else begin
			frm_we    = acc && (mode == MODE_WRITE_BYTE) && !oob_in;
			frm_re    = acc && (mode == MODE_READ_BYTE);
			frm_addr  = FA_W'(address);
			frm_wdata = byte_value;
		end
	end

	pfsc_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_addr),
		.wdata (frm_wdata),
		.re    (frm_re),
		.raddr (frm_addr),
		.rdata (frame_rdata)
	);

	pfsc_ram #(
		.WIDTH (RULE_BITS),
		.DEPTH (RULE_COUNT)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (ridx),
		.wdata (ru_s1),
		.re    (seq_rule_re),
		.raddr (seq_rule_raddr),
		.rdata (rule_rword)
	);

	assign rule_rdata = rule_t'(rule_rword);

	pfsc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (acc && (mode == MODE_ADVANCE)),
		.len         (len),
		.cmask       (cmask_q),
		.rule_valid  (rvalid_q),
		.rule_rdata  (rule_rdata),
		.frame_rdata (frame_rdata),
		.rule_re     (seq_rule_re),
		.rule_raddr  (seq_rule_raddr),
		.frm_req     (seq_req),
		.res         (seq_res),
		.busy        (seq_busy)
	);

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.done |-> !vld_s1)
		else $error("advance result would overwrite a pending result");
	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (mode == MODE_ADVANCE)) |=> seq_busy)
		else $error("advance transfer did not start the sequencer");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_go) |=> (vld_s1 && $stable(mode_s1) && $stable(sts_s1)))
		else $error("result stage lost an item under stall");
	a_rule_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rule_we |-> (rem < ADDR_W'(RULE_COUNT)))
		else $error("rule index out of range");
endmodule
`default_nettype wire

### hw/rtl/pfsc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pfsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/pfsc_seq.sv
// Advance sequencer: rule walk and checksum refresh over the frame memory.
`default_nettype none
module pfsc_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pfsc_pkg::LEN_W-1:0]      len,
	input  wire logic [pfsc_pkg::MASK_W-1:0]     cmask,
	input  wire logic [pfsc_pkg::RULE_COUNT-1:0] rule_valid,
	input  wire pfsc_pkg::rule_t                 rule_rdata,
	input  wire logic [7:0]                      frame_rdata,
	output logic                                 rule_re,
	output logic [pfsc_pkg::RULE_W-1:0]          rule_raddr,
	output pfsc_pkg::frm_req_t                   frm_req,
	output pfsc_pkg::seq_res_t                   res,
	output logic                                 busy
);
	import pfsc_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] R_FETCH = 5'd1;
	localparam logic [4:0] R_CHECK = 5'd2;
	localparam logic [4:0] R_RD    = 5'd3;
	localparam logic [4:0] R_CAP   = 5'd4;
	localparam logic [4:0] R_CALC  = 5'd5;
	localparam logic [4:0] R_WR    = 5'd6;
	localparam logic [4:0] R_NEXT  = 5'd7;
	localparam logic [4:0] C_START = 5'd8;
	localparam logic [4:0] C_ET0   = 5'd9;
	localparam logic [4:0] C_ET1   = 5'd10;
	localparam logic [4:0] C_IHL   = 5'd11;
	localparam logic [4:0] C_Z0    = 5'd12;
	localparam logic [4:0] C_Z1    = 5'd13;
	localparam logic [4:0] C_SUM   = 5'd14;
	localparam logic [4:0] C_ACC   = 5'd15;
	localparam logic [4:0] C_FOLD  = 5'd16;
	localparam logic [4:0] C_W0    = 5'd17;
	localparam logic [4:0] C_W1    = 5'd18;
	localparam logic [4:0] C_FRAG  = 5'd19;
	localparam logic [4:0] C_FR0   = 5'd20;
	localparam logic [4:0] C_FR1   = 5'd21;
	localparam logic [4:0] C_PROTO = 5'd22;
	localparam logic [4:0] C_TOT0  = 5'd23;
	localparam logic [4:0] C_TOT1  = 5'd24;
	localparam logic [4:0] C_L4    = 5'd25;
	localparam logic [4:0] S_DONE  = 5'd26;

	localparam logic [1:0] K_IP     = 2'd0;
	localparam logic [1:0] K_PSEUDO = 2'd1;
	localparam logic [1:0] K_DATA   = 2'd2;

	logic [4:0]        state_q;
	logic [RULE_W-1:0] rule_q;
	logic [ADDR_W-1:0] off_q;
	logic [2:0]        w_q;
	logic [2:0]        bcnt_q;
	logic [31:0]       cur_q;
	logic [PA_W-1:0]   eth_q;
	logic [7:0]        hi_q;
	logic [5:0]        ihl_q;
	logic [PA_W-1:0]   data_at_q;
	logic [7:0]        proto_q;
	logic [15:0]       tot_q;
	logic [CNT_W-1:0]  dlen_q;
	logic [PA_W-1:0]   wpos_q;
	logic [PA_W-1:0]   sp_q;
	logic [CNT_W-1:0]  si_q;
	logic [CNT_W-1:0]  sn_q;
	logic [31:0]       sum_q;
	logic [15:0]       res_q;
	logic [1:0]        kind_q;
	logic              udp_q;
	logic [1:0]        sts_q;
	logic [PA_W-1:0]   rd_pa_q;

	logic [PA_W-1:0]   lenx;
	logic [7:0]        dm;
	logic [15:0]       et;
	logic              vlan_more;
	logic              rd_en;
	logic [PA_W-1:0]   rd_pa;
	logic              wr_en;
	logic [PA_W-1:0]   wr_pa;
	logic [7:0]        wr_data;
	logic [1:0]        wsel;
	logic [31:0]       msk;
	logic [31:0]       stepped;
	logic [PA_W-1:0]   hav;
	logic [PA_W-1:0]   avail;
	logic [15:0]       diff;
	logic [CNT_W-1:0]  dl;
	logic              ic_en;
	logic              tu_en;
	logic [15:0]       fold_res;

	assign lenx      = PA_W'(len);
	assign dm        = (rd_pa_q < lenx) ? frame_rdata : 8'h00;
	assign et        = {hi_q, dm};
	assign vlan_more = (et == ETYPE_VLAN) && ((eth_q + PA_W'(4)) <= lenx);
	assign wsel      = 2'(w_q - 3'd1 - bcnt_q);
	assign msk       = (w_q == 3'd4) ? 32'hffff_ffff :
	                   (w_q == 3'd2) ? 32'h0000_ffff : 32'h0000_00ff;
	assign stepped   = cur_q + rule_rdata.step;
	assign hav       = lenx - eth_q;
	assign avail     = (data_at_q < lenx) ? (lenx - data_at_q) : '0;
	assign diff      = (tot_q > 16'(ihl_q)) ? (tot_q - 16'(ihl_q)) : 16'h0000;
	assign dl        = ({1'b0, diff} > 17'(avail)) ? CNT_W'(avail) : diff;
	assign ic_en     = ((proto_q == PROTO_ICMP) && cmask[CK_ICMP]) ||
	                   ((proto_q == PROTO_IGMP) && cmask[CK_IGMP]);
	assign tu_en     = ((proto_q == PROTO_TCP) && cmask[CK_TCP]) ||
	                   ((proto_q == PROTO_UDP) && cmask[CK_UDP]);
	// a UDP checksum of zero goes out as all ones
	assign fold_res  = (udp_q && (kind_q == K_DATA) && (sum_q[15:0] == 16'hffff)) ?
	                   16'hffff : ~sum_q[15:0];

	always_comb begin
		rd_en   = 1'b0;
		rd_pa   = '0;
		wr_en   = 1'b0;
		wr_pa   = '0;
		wr_data = 8'h00;
		unique case (state_q)
			R_RD: begin
				rd_en = 1'b1;
				rd_pa = PA_W'(off_q) + PA_W'(bcnt_q);
			end
			R_WR: begin
				wr_en   = 1'b1;
				wr_pa   = PA_W'(off_q) + PA_W'(bcnt_q);
				wr_data = cur_q[8*wsel +: 8];
			end
			C_START: begin
				rd_en = lenx >= PA_W'(MIN_FRAME);
				rd_pa = PA_W'(ETH_HDR - 2);
			end
			C_ET0: begin
				rd_en = 1'b1;
				rd_pa = eth_q - PA_W'(1);
			end
			C_ET1: begin
				rd_en = 1'b1;
				rd_pa = vlan_more ? (eth_q + PA_W'(2)) : eth_q;
			end
			C_Z0: begin
				wr_en = 1'b1;
				wr_pa = wpos_q;
			end
			C_Z1: begin
				wr_en = 1'b1;
				wr_pa = wpos_q + PA_W'(1);
			end
			C_SUM: begin
				rd_en = si_q != sn_q;
				rd_pa = sp_q + PA_W'(si_q);
			end
			C_W0: begin
				wr_en   = 1'b1;
				wr_pa   = wpos_q;
				wr_data = res_q[15:8];
			end
			C_W1: begin
				wr_en   = 1'b1;
				wr_pa   = wpos_q + PA_W'(1);
				wr_data = res_q[7:0];
			end
			C_FRAG: begin
				rd_en = 1'b1;
				rd_pa = eth_q + PA_W'(6);
			end
			C_FR0: begin
				rd_en = 1'b1;
				rd_pa = eth_q + PA_W'(7);
			end
			C_FR1: begin
				rd_en = 1'b1;
				rd_pa = eth_q + PA_W'(9);
			end
			C_PROTO: begin
				rd_en = 1'b1;
				rd_pa = eth_q + PA_W'(2);
			end
			C_TOT0: begin
				rd_en = 1'b1;
				rd_pa = eth_q + PA_W'(3);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		frm_req.re    = rd_en;
		frm_req.we    = wr_en && (wr_pa < lenx);
		frm_req.addr  = rd_en ? FA_W'(rd_pa) : FA_W'(wr_pa);
		frm_req.wdata = wr_data;
	end

	assign rule_re    = state_q == R_FETCH;
	assign rule_raddr = rule_q;
	assign res.done   = state_q == S_DONE;
	assign res.status = sts_q;
	assign busy       = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start) state_q <= R_FETCH;
				R_FETCH: state_q <= R_CHECK;
				R_CHECK: begin
					if (rule_valid[rule_q] &&
					    ((rule_rdata.width == 3'd1) || (rule_rdata.width == 3'd2) ||
					     (rule_rdata.width == 3'd4)) &&
					    ((PA_W'(rule_rdata.offset) + PA_W'(rule_rdata.width)) <= lenx)) begin
						state_q <= R_RD;
					end else begin
						state_q <= R_NEXT;
					end
				end
				R_RD:    state_q <= R_CAP;
				R_CAP:   state_q <= ((bcnt_q + 3'd1) == w_q) ? R_CALC : R_RD;
				R_CALC:  state_q <= R_WR;
				R_WR:    if ((bcnt_q + 3'd1) == w_q) state_q <= R_NEXT;
				R_NEXT:  state_q <= (rule_q == RULE_W'(RULE_COUNT - 1)) ? C_START : R_FETCH;
				C_START: state_q <= (lenx < PA_W'(MIN_FRAME)) ? S_DONE : C_ET0;
				C_ET0:   state_q <= C_ET1;
				C_ET1: begin
					if (vlan_more) begin
						state_q <= C_ET0;
					end else if ((et != ETYPE_IPV4) || ((eth_q + PA_W'(IP_MIN)) > lenx)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= C_IHL;
					end
				end
				C_IHL:   state_q <= cmask[CK_IP] ? C_Z0 : C_FRAG;
				C_Z0:    state_q <= C_Z1;
				C_Z1:    state_q <= C_SUM;
				C_SUM: begin
					if (si_q != sn_q) begin
						state_q <= C_ACC;
					end else if (kind_q != K_PSEUDO) begin
						state_q <= C_FOLD;
					end
				end
				C_ACC:   state_q <= C_SUM;
				C_FOLD:  if (sum_q[31:16] == 16'h0000) state_q <= C_W0;
				C_W0:    state_q <= C_W1;
				C_W1:    state_q <= (kind_q == K_IP) ? C_FRAG : S_DONE;
				C_FRAG:  state_q <= C_FR0;
				C_FR0:   state_q <= C_FR1;
				C_FR1:   state_q <= ({hi_q[4:0], dm} != 13'h0000) ? S_DONE : C_PROTO;
				C_PROTO: state_q <= C_TOT0;
				C_TOT0:  state_q <= C_TOT1;
				C_TOT1:  state_q <= C_L4;
				C_L4:    state_q <= (ic_en || tu_en) ? C_Z0 : S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pa_q <= rd_pa;
		end
		unique case (state_q)
			S_IDLE: rule_q <= '0;
			R_CHECK: begin
				off_q  <= rule_rdata.offset;
				w_q    <= rule_rdata.width;
				bcnt_q <= 3'd0;
				cur_q  <= 32'h0;
			end
			R_CAP: begin
				cur_q  <= {cur_q[23:0], dm};
				bcnt_q <= bcnt_q + 3'd1;
			end
			R_CALC: begin
				// reload the base once the stepped value passes the limit
				cur_q  <= (stepped > (rule_rdata.rmax & msk)) ? (rule_rdata.base & msk) : stepped;
				bcnt_q <= 3'd0;
			end
			R_WR:   bcnt_q <= bcnt_q + 3'd1;
			R_NEXT: rule_q <= rule_q + RULE_W'(1);
			C_START: begin
				eth_q <= PA_W'(ETH_HDR);
				udp_q <= 1'b0;
				sts_q <= ST_NOT_IP;
			end
			C_ET0:  hi_q <= dm;
			C_ET1:  if (vlan_more) eth_q <= eth_q + PA_W'(4);
			C_IHL: begin
				ihl_q     <= {dm[3:0], 2'b00};
				data_at_q <= eth_q + PA_W'({dm[3:0], 2'b00});
				wpos_q    <= eth_q + PA_W'(10);
				sp_q      <= eth_q;
				sn_q      <= (PA_W'({dm[3:0], 2'b00}) < hav) ? CNT_W'({dm[3:0], 2'b00}) :
				             CNT_W'(hav);
				si_q      <= '0;
				sum_q     <= 32'h0;
				kind_q    <= K_IP;
			end
			C_SUM: begin
				if ((si_q == sn_q) && (kind_q == K_PSEUDO)) begin
					sum_q  <= sum_q + 32'(proto_q) + 32'(dlen_q);
					sp_q   <= data_at_q;
					sn_q   <= dlen_q;
					si_q   <= '0;
					kind_q <= K_DATA;
				end
			end
			C_ACC: begin
				sum_q <= sum_q + (si_q[0] ? 32'(dm) : 32'({dm, 8'h00}));
				si_q  <= si_q + CNT_W'(1);
			end
			C_FOLD: begin
				if (sum_q[31:16] != 16'h0000) begin
					sum_q <= 32'(sum_q[15:0]) + 32'(sum_q[31:16]);
				end else begin
					res_q <= fold_res;
				end
			end
			C_W1:   sts_q <= ST_FULL;
			C_FR0:  hi_q <= dm;
			C_FR1:  if ({hi_q[4:0], dm} != 13'h0000) sts_q <= ST_FRAG;
			C_PROTO: proto_q <= dm;
			C_TOT0: hi_q <= dm;
			C_TOT1: begin
				tot_q <= {hi_q, dm};
				sts_q <= ST_FULL;
			end
			C_L4: begin
				dlen_q <= dl;
				si_q   <= '0;
				sum_q  <= 32'h0;
				if (ic_en) begin
					wpos_q <= data_at_q + PA_W'(2);
					sp_q   <= data_at_q;
					sn_q   <= dl;
					kind_q <= K_DATA;
				end else begin
					wpos_q <= data_at_q + ((proto_q == PROTO_TCP) ? PA_W'(16) : PA_W'(6));
					sp_q   <= eth_q + PA_W'(12);
					sn_q   <= CNT_W'(8);
					kind_q <= K_PSEUDO;
					udp_q  <= proto_q == PROTO_UDP;
				end
			end
			default: begin
			end
		endcase
	end

	// rules and frame bytes are never read and written in the same cycle
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(frm_req.re && frm_req.we))
		else $error("sequencer read and write collide");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !busy)
		else $error("sequencer did not return to idle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == R_FETCH))
		else $error("advance start lost");
endmodule
`default_nettype wire

### test/packet_field_step_and_checksum_tb.sv
// Testbench for the packet field stepper with IPv4 checksum refresh.
module packet_field_step_and_checksum_tb;
	import pfsc_pkg::*;

	localparam int WATCHDOG   = 100000;
	localparam int FILL_BYTES = 256;
	localparam int RULE_SPAN  = FILL_BYTES - 8;

	typedef struct {
		logic [1:0]        md;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        bval;
		logic              en;
		logic [ADDR_W-1:0] off;
		logic [2:0]        wid;
		logic [31:0]       stp;
		logic [31:0]       bas;
		logic [31:0]       mx;
	} xfer_t;

	typedef struct {
		logic [7:0] bout;
		logic [1:0] st;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_FRAME_LENGTH;
	logic [FLEN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_READ_BYTE;
	logic [ADDR_W-1:0] address = '0;
	logic [7:0] byte_value = '0;
	logic rule_enable = 1'b0;
	logic [ADDR_W-1:0] rule_offset = '0;
	logic [2:0] rule_width = '0;
	logic [31:0] rule_step = '0;
	logic [31:0] rule_base = '0;
	logic [31:0] rule_max = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] byte_out;
	logic [1:0] advance_status;

	packet_field_step_and_checksum u_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0] frame_img [FRAME_BYTES];
	logic rule_on [RULE_COUNT];
	int unsigned rule_off [RULE_COUNT], rule_wid [RULE_COUNT];
	int unsigned rule_stp [RULE_COUNT], rule_bas [RULE_COUNT], rule_mx [RULE_COUNT];
	int unsigned frame_len_reg = 0, ck_mask_reg = 0;

	xfer_t stim_q[$];
	reply_t reply_q[$];
	xfer_t cur;
	int sender_idle_pct = 27, recv_idle_pct = 60;
	int send_calm = 0, recv_calm = 0;
	int errors = 0, results_seen = 0, items_sent = 0, advances_sent = 0;
	int status_hits [4];
	int quiet = 0;

	function automatic int unsigned rd8(int unsigned a, int unsigned len);
		return (a < len) ? int'(frame_img[a]) : 0;
	endfunction

	function automatic int unsigned rd16(int unsigned a, int unsigned len);
		return (rd8(a, len) << 8) | rd8(a + 1, len);
	endfunction

	function automatic void wr16(int unsigned a, int unsigned v, int unsigned len);
		if (a < len) frame_img[a] = v[15:8];
		if (a + 1 < len) frame_img[a + 1] = v[7:0];
	endfunction

	function automatic int unsigned sum_bytes(int unsigned acc, int unsigned start,
			int unsigned cnt, int unsigned len);
		int unsigned i;
		i = 0;
		while (i + 1 < cnt) begin
			acc += rd16(start + i, len);
			i += 2;
		end
		if (i < cnt) acc += rd8(start + i, len) << 8;
		return acc;
	endfunction

	function automatic int unsigned fold_sum(int unsigned acc);
		while (acc >> 16) acc = (acc & 32'hffff) + (acc >> 16);
		return (~acc) & 32'hffff;
	endfunction

	function automatic void step_fields(int unsigned len);
		int unsigned off, w, val, msk;
		for (int r = 0; r < RULE_COUNT; r++) begin
			off = rule_off[r];
			w = rule_wid[r];
			if (!rule_on[r] || off + w > len) continue;
			if (w != 1 && w != 2 && w != 4) continue;
			val = 0;
			for (int b = 0; b < w; b++) val = (val << 8) | frame_img[off + b];
			msk = (w == 4) ? 32'hffffffff : ((32'd1 << (8 * w)) - 1);
			val += rule_stp[r];
			if (val > (rule_mx[r] & msk)) val = rule_bas[r] & msk;
			for (int b = 0; b < w; b++) frame_img[off + b] = 8'(val >> (8 * (w - 1 - b)));
		end
	endfunction

	function automatic logic [1:0] refresh_sums(int unsigned len);
		int unsigned eth, etype, ihl, proto, tot, data_at, avail, dlen, pos, acc, res, n;
		eth = ETH_HDR;
		if (len < MIN_FRAME) return ST_NOT_IP;
		etype = rd16(12, len);
		while (etype == ETYPE_VLAN && eth + 4 <= len) begin
			eth += 4;
			etype = rd16(eth - 2, len);
		end
		if (etype != ETYPE_IPV4 || eth + IP_MIN > len) return ST_NOT_IP;
		ihl = (frame_img[eth] & 8'h0f) * 4;
		if (ck_mask_reg[CK_IP]) begin
			n = (ihl < len - eth) ? ihl : len - eth;
			wr16(eth + 10, 0, len);
			wr16(eth + 10, fold_sum(sum_bytes(0, eth, n, len)), len);
		end
		if (rd16(eth + 6, len) & 32'h1fff) return ST_FRAG;
		proto = frame_img[eth + 9];
		tot = rd16(eth + 2, len);
		data_at = eth + ihl;
		avail = (data_at < len) ? len - data_at : 0;
		dlen = (tot > ihl) ? tot - ihl : 0;
		if (dlen > avail) dlen = avail;
		if ((proto == PROTO_ICMP && ck_mask_reg[CK_ICMP]) ||
				(proto == PROTO_IGMP && ck_mask_reg[CK_IGMP])) begin
			wr16(data_at + 2, 0, len);
			wr16(data_at + 2, fold_sum(sum_bytes(0, data_at, dlen, len)), len);
		end else if ((proto == PROTO_TCP && ck_mask_reg[CK_TCP]) ||
				(proto == PROTO_UDP && ck_mask_reg[CK_UDP])) begin
			pos = data_at + ((proto == PROTO_TCP) ? 16 : 6);
			wr16(pos, 0, len);
			acc = sum_bytes(0, eth + 12, 8, len);
			acc += proto;
			acc += dlen & 32'hffff;
			acc = sum_bytes(acc, data_at, dlen, len);
			res = fold_sum(acc);
			if (proto == PROTO_UDP && res == 0) res = 32'hffff;
			wr16(pos, res, len);
		end
		return ST_FULL;
	endfunction

	function automatic reply_t compute_reply(xfer_t x);
		reply_t rp;
		int unsigned len, r;
		len = (frame_len_reg > FRAME_BYTES) ? FRAME_BYTES : frame_len_reg;
		rp.bout = 8'd0;
		rp.st = ST_NONE;
		case (x.md)
			MODE_WRITE_BYTE: frame_img[x.addr] = x.bval;
			MODE_WRITE_RULE: begin
				r = x.addr % RULE_COUNT;
				rule_on[r] = x.en;
				rule_off[r] = x.off;
				rule_wid[r] = x.wid;
				rule_stp[r] = x.stp;
				rule_bas[r] = x.bas;
				rule_mx[r] = x.mx;
			end
			MODE_ADVANCE: begin
				step_fields(len);
				rp.st = refresh_sums(len);
			end
			default: rp.bout = frame_img[x.addr];
		endcase
		return rp;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return $urandom_range(0, 300);
			default: return $urandom;
		endcase
	endfunction

	function automatic xfer_t random_xfer(logic [1:0] m);
		xfer_t x;
		x.md = m;
		x.addr = ADDR_W'($urandom);
		x.bval = 8'($urandom);
		x.en = 1'($urandom);
		x.off = ADDR_W'($urandom);
		x.wid = 3'($urandom);
		x.stp = $urandom;
		x.bas = $urandom;
		x.mx = $urandom;
		return x;
	endfunction

	function automatic void push_byte(int unsigned a, logic [7:0] v);
		xfer_t x;
		x = random_xfer(MODE_WRITE_BYTE);
		x.addr = ADDR_W'(a);
		x.bval = v;
		stim_q = {stim_q, x};
	endfunction

	function automatic void push_rule(int unsigned lo, int unsigned hi);
		xfer_t x;
		x = random_xfer(MODE_WRITE_RULE);
		x.en = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 7) != 0) x.off = ADDR_W'($urandom_range(lo, hi));
		else x.off = ADDR_W'($urandom_range(0, RULE_SPAN - 1));
		case ($urandom_range(0, 4))
			0: x.wid = 1;
			1: x.wid = 2;
			2: x.wid = 4;
			default: x.wid = 3'($urandom);
		endcase
		x.stp = pick_word();
		x.bas = pick_word();
		x.mx = pick_word();
		stim_q = {stim_q, x};
	endfunction

	// lay a plausible Ethernet/IPv4 header over the start of the template
	function automatic void push_header(int unsigned eff);
		logic [7:0] hdr [80];
		int unsigned tags, eth, tot;
		logic [15:0] frag;
		logic [7:0] proto;
		foreach (hdr[i]) hdr[i] = 8'($urandom);
		tags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		for (int t = 0; t < tags; t++) {hdr[12 + 4 * t], hdr[13 + 4 * t]} = ETYPE_VLAN;
		eth = ETH_HDR + 4 * tags;
		{hdr[eth - 2], hdr[eth - 1]} = ($urandom_range(0, 9) != 0) ? ETYPE_IPV4 : 16'($urandom);
		hdr[eth] = ($urandom_range(0, 4) != 0) ? 8'h45 : 8'($urandom);
		tot = ($urandom_range(0, 3) != 0) ? ((eff > eth) ? eff - eth : 0) : $urandom_range(0, 65535);
		{hdr[eth + 2], hdr[eth + 3]} = 16'(tot);
		case ($urandom_range(0, 5))
			0: frag = 16'($urandom);
			1: frag = 16'h4000;
			default: frag = 16'h0;
		endcase
		{hdr[eth + 6], hdr[eth + 7]} = frag;
		case ($urandom_range(0, 5))
			0: proto = PROTO_ICMP;
			1: proto = PROTO_IGMP;
			2: proto = PROTO_TCP;
			3: proto = PROTO_UDP;
			4: proto = PROTO_UDP;
			default: proto = 8'($urandom);
		endcase
		hdr[eth + 9] = proto;
		foreach (hdr[i]) push_byte(i, hdr[i]);
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (stim_q.size() != 0 || in_valid || reply_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= FLEN_W'(val);
		if (idx == CFG_FRAME_LENGTH) frame_len_reg = val & 32'hfff;
		else ck_mask_reg = val & 32'h1f;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int unsigned flen, int unsigned cmask, int unsigned n);
		int unsigned eff, lim, k;
		xfer_t x;
		drain();
		write_reg(CFG_FRAME_LENGTH, flen);
		write_reg(CFG_CHECKSUM_MASK, cmask);
		eff = (flen > FRAME_BYTES) ? FRAME_BYTES : flen;
		// keep rule fields inside the filled part of the template
		lim = (eff < RULE_SPAN) ? eff : RULE_SPAN;
		push_header(eff);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30) begin
				stim_q = {stim_q, random_xfer(MODE_ADVANCE)};
			end else if (k < 50) begin
				push_rule(0, (lim > 4) ? lim - 1 : 4);
			end else if (k < 75) begin
				x = random_xfer(MODE_WRITE_BYTE);
				if ($urandom_range(0, 1)) x.addr = ADDR_W'($urandom_range(0, 79));
				stim_q = {stim_q, x};
			end else begin
				x = random_xfer(MODE_READ_BYTE);
				if ($urandom_range(0, 1)) x.addr = ADDR_W'($urandom_range(0, 79));
				else x.addr = ADDR_W'($urandom_range(0, FILL_BYTES - 1));
				stim_q = {stim_q, x};
			end
		end
	endtask

	function automatic bit idle_now(int pct, ref int calm);
		if (calm > 0) begin
			calm--;
			return 1'b0;
		end
		if ($urandom_range(0, 99) < 2) calm = $urandom_range(10, 40);
		return ($urandom_range(0, 99) < pct);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				reply_q = {reply_q, compute_reply(cur)};
				items_sent++;
				if (cur.md == MODE_ADVANCE) advances_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (stim_q.size() != 0 && !idle_now(sender_idle_pct, send_calm)) begin
					cur = stim_q.pop_front();
					mode <= cur.md;
					address <= cur.addr;
					byte_value <= cur.bval;
					rule_enable <= cur.en;
					rule_offset <= cur.off;
					rule_width <= cur.wid;
					rule_step <= cur.stp;
					rule_base <= cur.bas;
					rule_max <= cur.mx;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (reply_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transfer: byte %0h status %0d",
						byte_out, advance_status);
				end else begin
					want = reply_q.pop_front();
					status_hits[advance_status]++;
					if (want.bout !== byte_out || want.st !== advance_status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: byte exp %0h got %0h, status exp %0d got %0d",
								want.bout, byte_out, want.st, advance_status);
					end
				end
			end
			out_stall <= idle_now(recv_idle_pct, recv_calm);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("watchdog expired with %0d transfers outstanding", reply_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned lens [12];
		foreach (status_hits[i]) status_hits[i] = 0;
		foreach (rule_on[i]) rule_on[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// fill the low part of the template; the random reads and rule fields stay inside it
		for (int a = 0; a < FILL_BYTES; a++) push_byte(a, 8'($urandom));
		drain();

		// directed: empty and short frames, the extremes of the rule fields
		write_reg(CFG_FRAME_LENGTH, 0);
		write_reg(CFG_CHECKSUM_MASK, 0);
		push_byte(FRAME_BYTES - 1, 8'($urandom));
		begin
			xfer_t x;
			x = random_xfer(MODE_WRITE_RULE);
			x.addr = '0; x.en = 1; x.off = 20; x.wid = 4;
			x.stp = 32'hffffffff; x.bas = 32'hffffffff; x.mx = 32'hffffffff;
			stim_q = {stim_q, x};
			x.addr = '1; x.off = '1; x.wid = 1; x.stp = 1; x.bas = 0; x.mx = 0;
			stim_q = {stim_q, x};
			x.addr = 2; x.off = 16; x.wid = 2; x.stp = 32'h10000; x.bas = 5; x.mx = 32'hffff;
			stim_q = {stim_q, x};
			x.addr = 3; x.en = 0; x.wid = 7;
			stim_q = {stim_q, x};
			stim_q = {stim_q, random_xfer(MODE_ADVANCE)};
			x = random_xfer(MODE_READ_BYTE);
			x.addr = '1;
			stim_q = {stim_q, x};
			x.addr = '0;
			stim_q = {stim_q, x};
		end
		run_phase(33, 31, 6);
		run_phase(34, 31, 8);

		// the oversized length runs with the header checksum only
		lens = '{256, 4095, 60, 100, 42, 128, 64, 200, 80, 150, 48, 120};
		foreach (lens[i]) begin
			if (i == 4) begin
				sender_idle_pct = 60;
				recv_idle_pct = 27;
			end else if (i == 8) begin
				sender_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_phase(lens[i], (i == 1) ? (1 << CK_IP) :
				((i == 2) ? 0 : ((i == 3) ? 31 : $urandom_range(0, 31))), 30);
		end
		drain();
		repeat (40) @(posedge clk);

		$display("%0d items sent (%0d advances), %0d results checked, %0d mismatches",
			items_sent, advances_sent, results_seen, errors);
		$display("status counts: full %0d, not IPv4 %0d, fragment %0d, no advance %0d",
			status_hits[ST_FULL], status_hits[ST_NOT_IP], status_hits[ST_FRAG],
			status_hits[ST_NONE]);
		if (errors == 0 && reply_q.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
